### src/sequential_io_stream_detector_macros.svh
// Assertion macros shared by the stream detector checkers.
`ifndef SEQUENTIAL_IO_STREAM_DETECTOR_MACROS_SVH
`define SEQUENTIAL_IO_STREAM_DETECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SIOSD_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("stream detector check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SIOSD_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("stream detector check failed");

`endif

### src/siosd_pkg.sv
// Shared constants, register codes and bundle types of the stream detector.
`timescale 1ns / 1ps
package siosd_pkg;

    localparam int FLOW_SLOTS = 32;
    localparam int SLOT_W     = $clog2(FLOW_SLOTS);
    localparam int SECTOR_W   = 48;
    localparam int LEN_W      = 16;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int GAP_W      = CFG_W + 1;
    localparam int END_W      = SECTOR_W + 1;
    localparam int LIM_W      = SECTOR_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_SEQ_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_GAP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKWARD_GAP  = 2'd2;

    typedef struct packed {
        logic [SECTOR_W-1:0] last_start;
        logic [LEN_W-1:0]    last_length;
        logic [SECTOR_W-1:0] seq_count;
    } flow_entry_t;

    typedef struct packed {
        logic [CFG_W-1:0] seq_threshold_kb;
        logic [CFG_W-1:0] forward_gap_kb;
        logic [CFG_W-1:0] backward_gap_kb;
    } cfg_t;

    typedef struct packed {
        logic [SECTOR_W-1:0] start;
        logic [LEN_W-1:0]    length;
        logic [END_W-1:0]    stop;
    } req_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] pos;
        logic [SLOT_W-1:0] slot;
    } probe_t;

    typedef struct packed {
        logic                valid;
        logic [SLOT_W-1:0]   pos;
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                fwd;
        logic                skip;
        logic [SECTOR_W-1:0] count;
    } match_t;

endpackage

### src/sequential_io_stream_detector.sv
// Top level of the sequential I/O stream detector with an LRU flow table.
// The walk reads the LRU-order RAM from the head, one position per cycle, then
// the flow entry at that position, and classifies it; it stops at the first hit,
// or at position FLOW_SLOTS-1 on a miss. Throughput: one item at a time; the next
// input beat is taken only after the result beat is emitted, which out_stall can hold.
// Reset: async, clears config and per-entry valid bits; no clearing pass.
`timescale 1ns / 1ps
module sequential_io_stream_detector (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [siosd_pkg::SECTOR_W-1:0]      start_sector,
    input  logic [siosd_pkg::LEN_W-1:0]         length_sectors,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                skip,
    output logic                                matched,
    input  logic                                cfg_write,
    input  logic [siosd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [siosd_pkg::CFG_W-1:0]         cfg_data
);

    localparam int SLOTS    = siosd_pkg::FLOW_SLOTS;
    localparam int SLOT_W   = siosd_pkg::SLOT_W;
    localparam int CNT_W    = SLOT_W + 1;
    localparam int SECTOR_W = siosd_pkg::SECTOR_W;
    localparam int LEN_W    = siosd_pkg::LEN_W;
    localparam int END_W    = siosd_pkg::END_W;
    localparam int FLOW_W   = $bits(siosd_pkg::flow_entry_t);
    localparam logic [CNT_W-1:0]  SLOT_COUNT = CNT_W'(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_POS   = SLOT_W'(SLOTS - 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

    state_t                 state_reg;
    siosd_pkg::cfg_t        cfg_reg;
    siosd_pkg::req_t        req_reg;
    logic [CNT_W-1:0]       rd_cnt_reg;
    logic                   b_valid_reg;
    logic [SLOT_W-1:0]      b_pos_reg;
    logic                   lru_rvld_reg;
    siosd_pkg::probe_t      c_probe_reg;
    logic                   flow_rvld_reg;
    logic [SLOT_W-1:0]      prev_slot_reg;
    logic                   fin_en_reg;
    logic                   fin_hit_reg;
    logic                   fin_fwd_reg;
    logic                   fin_skip_reg;
    logic [SLOT_W-1:0]      fin_slot_reg;
    logic [SECTOR_W-1:0]    fin_count_reg;
    logic                   out_valid_reg;
    logic                   skip_reg;
    logic                   matched_reg;
    logic [SLOTS-1:0]       lru_vld_reg;
    logic [SLOTS-1:0]       flow_vld_reg;

    logic                   in_accept;
    logic                   stop;
    logic                   rd_issue;
    logic                   emit;
    logic [SLOT_W-1:0]      lru_raddr;
    logic [SLOT_W-1:0]      lru_rdata;
    logic [SLOT_W-1:0]      b_slot;
    logic                   lru_we;
    logic [SLOT_W-1:0]      lru_waddr;
    logic [SLOT_W-1:0]      lru_wdata;
    logic [FLOW_W-1:0]      flow_rdata;
    logic                   flow_we;
    siosd_pkg::flow_entry_t flow_wentry;
    siosd_pkg::flow_entry_t entry;
    siosd_pkg::match_t      m;

    // Only idle takes a new request; a finished result may still be waiting.
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;

    // Stop the walk at the first hit, or at the tail when nothing matched.
    assign stop     = m.valid && (m.hit || (m.pos == LAST_POS));
    assign rd_issue = (state_reg == S_WALK) && !stop && (rd_cnt_reg != SLOT_COUNT);
    assign emit     = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign lru_raddr = rd_cnt_reg[SLOT_W-1:0];
    // A never-written LRU entry holds its own position.
    assign b_slot    = lru_rvld_reg ? lru_rdata : b_pos_reg;
    // A never-written flow entry reads as all zero.
    assign entry     = flow_rvld_reg ? siosd_pkg::flow_entry_t'(flow_rdata) : '0;

    // LRU rewrite: while walking, shift each passed position down by one;
    // at the end, drop the chosen slot into the head.
    always_comb
    begin
        lru_we    = 1'b0;
        lru_waddr = '0;
        lru_wdata = '0;
        priority if (emit && fin_en_reg)
        begin
            lru_we    = 1'b1;
            lru_wdata = fin_slot_reg;
        end
        else if (m.valid && (m.pos != '0))
        begin
            lru_we    = 1'b1;
            lru_waddr = m.pos;
            lru_wdata = prev_slot_reg;
        end
        else
        begin
            lru_we    = 1'b0;
        end
    end

    // Flow rewrite on a forward continuation or on reuse of the tail slot.
    assign flow_we                 = emit && fin_en_reg && (fin_fwd_reg || !fin_hit_reg);
    assign flow_wentry.last_start  = req_reg.start;
    assign flow_wentry.last_length = req_reg.length;
    assign flow_wentry.seq_count   = fin_count_reg;

    siosd_ram #(
        .DEPTH (SLOTS),
        .WIDTH (SLOT_W)
    ) u_lru_ram (
        .clk   (clk),
        .we    (lru_we),
        .waddr (lru_waddr),
        .wdata (lru_wdata),
        .raddr (lru_raddr),
        .rdata (lru_rdata)
    );

    siosd_ram #(
        .DEPTH (SLOTS),
        .WIDTH (FLOW_W)
    ) u_flow_ram (
        .clk   (clk),
        .we    (flow_we),
        .waddr (fin_slot_reg),
        .wdata (flow_wentry),
        .raddr (b_slot),
        .rdata (flow_rdata)
    );

    siosd_match u_match (
        .clk    (clk),
        .rst_n  (rst_n),
        .flush  (stop),
        .probe  (c_probe_reg),
        .entry  (entry),
        .req    (req_reg),
        .cfg    (cfg_reg),
        .result (m)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= '0;
            req_reg       <= '0;
            rd_cnt_reg    <= '0;
            b_valid_reg   <= 1'b0;
            b_pos_reg     <= '0;
            lru_rvld_reg  <= 1'b0;
            c_probe_reg   <= '0;
            flow_rvld_reg <= 1'b0;
            prev_slot_reg <= '0;
            fin_en_reg    <= 1'b0;
            fin_hit_reg   <= 1'b0;
            fin_fwd_reg   <= 1'b0;
            fin_skip_reg  <= 1'b0;
            fin_slot_reg  <= '0;
            fin_count_reg <= '0;
            out_valid_reg <= 1'b0;
            skip_reg      <= 1'b0;
            matched_reg   <= 1'b0;
            lru_vld_reg   <= '0;
            flow_vld_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    siosd_pkg::REG_SEQ_THRESHOLD: cfg_reg.seq_threshold_kb <= cfg_data;
                    siosd_pkg::REG_FORWARD_GAP:   cfg_reg.forward_gap_kb   <= cfg_data;
                    siosd_pkg::REG_BACKWARD_GAP:  cfg_reg.backward_gap_kb  <= cfg_data;
                    default: ;
                endcase
            end

            if (lru_we)
            begin
                lru_vld_reg[lru_waddr] <= 1'b1;
            end
            if (flow_we)
            begin
                flow_vld_reg[fin_slot_reg] <= 1'b1;
            end

            // Advance the read pipeline: LRU position, then flow entry.
            lru_rvld_reg      <= lru_vld_reg[lru_raddr];
            flow_rvld_reg     <= flow_vld_reg[b_slot];
            b_valid_reg       <= rd_issue;
            b_pos_reg         <= lru_raddr;
            c_probe_reg.valid <= b_valid_reg && !stop;
            c_probe_reg.pos   <= b_pos_reg;
            c_probe_reg.slot  <= b_slot;
            if (rd_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (m.valid)
            begin
                prev_slot_reg <= m.slot;
            end

            // Result beat register; hold it while the far side stalls.
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                skip_reg      <= fin_en_reg && fin_hit_reg && fin_skip_reg;
                matched_reg   <= fin_en_reg && fin_hit_reg;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        req_reg.start  <= start_sector;
                        req_reg.length <= length_sectors;
                        req_reg.stop   <= {1'b0, start_sector}
                                          + {{(END_W-LEN_W){1'b0}}, length_sectors};
                        rd_cnt_reg     <= '0;
                        fin_hit_reg    <= 1'b0;
                        fin_skip_reg   <= 1'b0;
                        // Zero threshold: answer at once, leave the table alone.
                        if (cfg_reg.seq_threshold_kb == '0)
                        begin
                            fin_en_reg <= 1'b0;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            fin_en_reg <= 1'b1;
                            state_reg  <= S_WALK;
                        end
                    end
                end
                S_WALK:
                begin
                    if (stop)
                    begin
                        fin_slot_reg  <= m.slot;
                        fin_hit_reg   <= m.hit;
                        fin_fwd_reg   <= m.fwd;
                        fin_skip_reg  <= m.skip;
                        fin_count_reg <= m.hit ? m.count
                                         : {{(SECTOR_W-LEN_W){1'b0}}, req_reg.length};
                        state_reg     <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (emit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign skip      = skip_reg;
    assign matched   = matched_reg;

endmodule

### src/siosd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module siosd_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/siosd_match.sv
// Two-stage flow match: precompute window bounds, then classify the probe.
`timescale 1ns / 1ps
module siosd_match (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     flush,
    input  siosd_pkg::probe_t        probe,
    input  siosd_pkg::flow_entry_t   entry,
    input  siosd_pkg::req_t          req,
    input  siosd_pkg::cfg_t          cfg,
    output siosd_pkg::match_t        result
);

    localparam int SECTOR_W = siosd_pkg::SECTOR_W;
    localparam int LEN_W    = siosd_pkg::LEN_W;
    localparam int GAP_W    = siosd_pkg::GAP_W;
    localparam int END_W    = siosd_pkg::END_W;
    localparam int LIM_W    = siosd_pkg::LIM_W;
    localparam int SLOT_W   = siosd_pkg::SLOT_W;

    logic [SECTOR_W-1:0] fgap;
    logic [SECTOR_W-1:0] bgap;
    logic [SECTOR_W-1:0] thresh;
    logic [END_W-1:0]    end_c;
    logic [SECTOR_W-1:0] fmin_c;
    logic [SECTOR_W-1:0] bmin_c;
    logic                rep_c;
    logic [END_W-1:0]    sum_c;
    logic [SECTOR_W-1:0] sat_c;

    logic                d_valid_reg;
    logic [SLOT_W-1:0]   d_pos_reg;
    logic [SLOT_W-1:0]   d_slot_reg;
    logic [END_W-1:0]    d_end_reg;
    logic [SECTOR_W-1:0] d_fmin_reg;
    logic [SECTOR_W-1:0] d_bmin_reg;
    logic                d_rep_reg;
    logic [SECTOR_W-1:0] d_count_reg;
    logic                d_gt_new_reg;
    logic                d_gt_old_reg;

    logic [LIM_W-1:0]    start_e;
    logic [LIM_W-1:0]    fwd_hi;
    logic [LIM_W-1:0]    bwd_lo;
    logic                fwd;
    logic                bwd;
    logic                hit;
    logic                skip;

    // Stage one: flow end, clipped gaps, saturated count, threshold tests.
    always_comb
    begin
        fgap   = {{(SECTOR_W-GAP_W){1'b0}}, cfg.forward_gap_kb, 1'b0};
        bgap   = {{(SECTOR_W-GAP_W){1'b0}}, cfg.backward_gap_kb, 1'b0};
        thresh = {{(SECTOR_W-GAP_W){1'b0}}, cfg.seq_threshold_kb, 1'b0};
        end_c  = {1'b0, entry.last_start} + {{(END_W-LEN_W){1'b0}}, entry.last_length};
        fmin_c = (entry.seq_count < fgap) ? entry.seq_count : fgap;
        bmin_c = (bgap < entry.seq_count) ? bgap : entry.seq_count;
        rep_c  = (req.start == entry.last_start) && (req.length == entry.last_length);
        sum_c  = {1'b0, entry.seq_count} + {{(END_W-LEN_W){1'b0}}, req.length};
        sat_c  = sum_c[SECTOR_W] ? {SECTOR_W{1'b1}} : sum_c[SECTOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= probe.valid && !flush;
        end
    end

    always_ff @(posedge clk)
    begin
        d_pos_reg    <= probe.pos;
        d_slot_reg   <= probe.slot;
        d_end_reg    <= end_c;
        d_fmin_reg   <= fmin_c;
        d_bmin_reg   <= bmin_c;
        d_rep_reg    <= rep_c;
        d_count_reg  <= sat_c;
        d_gt_new_reg <= sat_c > thresh;
        d_gt_old_reg <= entry.seq_count > thresh;
    end

    // Stage two: forward and backward windows; a borrow kills the backward test.
    always_comb
    begin
        start_e = {2'b00, req.start};
        fwd_hi  = {1'b0, d_end_reg} + {2'b00, d_fmin_reg};
        bwd_lo  = {1'b0, d_end_reg} - {2'b00, d_bmin_reg};
        fwd     = ({1'b0, req.start} >= d_end_reg) && (start_e <= fwd_hi);
        bwd     = (cfg.backward_gap_kb != '0) && !bwd_lo[LIM_W-1]
                  && (start_e >= bwd_lo) && (req.stop <= d_end_reg);
        hit     = 1'b0;
        skip    = 1'b0;
        priority if (d_rep_reg)
        begin
            hit = 1'b1;
        end
        else if (fwd)
        begin
            hit  = 1'b1;
            skip = d_gt_new_reg;
        end
        else if (bwd)
        begin
            hit  = 1'b1;
            skip = d_gt_old_reg;
        end
        else
        begin
            hit  = 1'b0;
            skip = 1'b0;
        end
    end

    assign result.valid = d_valid_reg;
    assign result.pos   = d_pos_reg;
    assign result.slot  = d_slot_reg;
    assign result.hit   = hit;
    assign result.fwd   = fwd && !d_rep_reg;
    assign result.skip  = skip;
    assign result.count = d_count_reg;

endmodule

### src/siosd_checker.sv
// Port-level checker for the stream detector and its bind to the top level.
`timescale 1ns / 1ps
`include "sequential_io_stream_detector_macros.svh"
module siosd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic skip,
    input logic matched
);

    // One request at a time: an accepted beat makes the input side busy.
    `SIOSD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // Skip comes only from a flow that matched.
    `SIOSD_ASSERT_SAME(a_skip_needs_match, out_valid, !skip || matched)

    // Hold a stalled result beat.
    `SIOSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(skip) && $stable(matched))

endmodule

bind sequential_io_stream_detector siosd_checker u_siosd_checker (.*);

### tb/sv/sequential_io_stream_detector_test.sv
// Self-checking testbench for the sequential I/O stream detector and its LRU flow table.
`timescale 1ns / 1ps
module sequential_io_stream_detector_test;

    localparam int FLOW_SLOTS = siosd_pkg::FLOW_SLOTS;
    localparam int SLOT_W     = siosd_pkg::SLOT_W;
    localparam int SECTOR_W   = siosd_pkg::SECTOR_W;
    localparam int LEN_W      = siosd_pkg::LEN_W;
    localparam int CFG_W      = siosd_pkg::CFG_W;
    localparam int CFG_IDX_W  = siosd_pkg::CFG_IDX_W;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          DRAIN_CYCLES  = 40;     // settle time after the last verdict
    localparam int          LONG_HOLD     = 400;    // receiver hold-off, in cycles
    localparam int          STREAM_COUNT  = 40;     // more than FLOW_SLOTS forces evictions
    localparam int          HOT_STREAMS   = 8;
    localparam int          MAX_REPORTS   = 100;
    localparam logic [63:0] SECTOR_LIMIT  = 64'h0000_FFFF_FFFF_FFFF;

    // Index 3 has no register behind it; a write there must leave the table alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic skip;
        logic matched;
    } flow_verdict_t;

    typedef enum int {
        KIND_FORWARD,
        KIND_REPEAT,
        KIND_BACKWARD,
        KIND_NOISE,
        KIND_RESTART
    } req_kind_t;

    // Scoreboard: own copy of the flow table, LRU order and registers,
    // plus the verdicts still owed by the block.
    class flow_verdict_board;
        logic [SECTOR_W-1:0] last_start [FLOW_SLOTS];
        logic [LEN_W-1:0]    last_len   [FLOW_SLOTS];
        logic [SECTOR_W-1:0] seq_count  [FLOW_SLOTS];
        logic [SLOT_W-1:0]   lru        [FLOW_SLOTS];
        logic [CFG_W-1:0]    thresh_kb;
        logic [CFG_W-1:0]    fwd_gap_kb;
        logic [CFG_W-1:0]    bwd_gap_kb;
        flow_verdict_t       owed [$];
        int                  mismatches;

        function new();
            mismatches = 0;
            for (int i = 0; i < FLOW_SLOTS; i++)
            begin
                last_start[i] = '0;
                last_len[i]   = '0;
                seq_count[i]  = '0;
                lru[i]        = SLOT_W'(i);
            end
            thresh_kb  = '0;
            fwd_gap_kb = '0;
            bwd_gap_kb = '0;
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                siosd_pkg::REG_SEQ_THRESHOLD: thresh_kb  = data;
                siosd_pkg::REG_FORWARD_GAP:   fwd_gap_kb = data;
                siosd_pkg::REG_BACKWARD_GAP:  bwd_gap_kb = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Move the slot at LRU position pos to the head.
        function void promote(input int pos);
            logic [SLOT_W-1:0] s;
            s = lru[pos];
            for (int k = pos; k > 0; k--)
                lru[k] = lru[k-1];
            lru[0] = s;
        endfunction

        // Walk the table from the head, update it and queue the verdict.
        function void note_request(input logic [SECTOR_W-1:0] start, input logic [LEN_W-1:0] len);
            logic [63:0]   s, l, thr, fgap, bgap, fend, cnt, lim, sum;
            int            slot;
            bit            take;
            flow_verdict_t v;
            v = '0;
            if (thresh_kb == '0)
            begin
                owed.push_back(v);
                return;
            end
            s    = 64'(start);
            l    = 64'(len);
            thr  = 64'(thresh_kb) * 2;
            fgap = 64'(fwd_gap_kb) * 2;
            bgap = 64'(bwd_gap_kb) * 2;
            for (int pos = 0; pos < FLOW_SLOTS; pos++)
            begin
                slot = lru[pos];
                fend = 64'(last_start[slot]) + 64'(last_len[slot]);
                cnt  = 64'(seq_count[slot]);
                take = 0;
                if (start == last_start[slot] && len == last_len[slot])
                begin
                    // repeat: refresh LRU position only
                    promote(pos);
                    v.matched = 1'b1;
                    owed.push_back(v);
                    return;
                end
                else if (s >= fend && s <= fend + ((cnt < fgap) ? cnt : fgap))
                begin
                    sum = cnt + l;
                    if (sum > SECTOR_LIMIT)
                        sum = SECTOR_LIMIT;
                    seq_count[slot]  = sum[SECTOR_W-1:0];
                    last_start[slot] = start;
                    last_len[slot]   = len;
                    take = 1;
                end
                else if (bwd_gap_kb != '0)
                begin
                    // wraps below zero on purpose; the huge bound then fails, as the block's borrow check does
                    lim = (bgap < cnt) ? bgap : cnt;
                    if (s >= fend - lim && s + l <= fend)
                        take = 1;
                end
                if (take)
                begin
                    promote(pos);
                    v.skip    = (64'(seq_count[slot]) > thr);
                    v.matched = 1'b1;
                    owed.push_back(v);
                    return;
                end
            end
            // no flow matched: recycle the tail slot
            slot = lru[FLOW_SLOTS-1];
            promote(FLOW_SLOTS-1);
            last_start[slot] = start;
            last_len[slot]   = len;
            seq_count[slot]  = SECTOR_W'(len);
            owed.push_back(v);
        endfunction

        task check_result(input logic skip_seen, input logic matched_seen);
            flow_verdict_t v;
            if (owed.size() == 0)
            begin
                report_mismatch($sformatf("result beat skip=%b matched=%b with nothing pending",
                                          skip_seen, matched_seen));
                return;
            end
            v = owed.pop_front();
            if (skip_seen !== v.skip)
                report_mismatch($sformatf("skip: got %b, want %b", skip_seen, v.skip));
            if (matched_seen !== v.matched)
                report_mismatch($sformatf("matched: got %b, want %b", matched_seen, v.matched));
        endtask

        task flush_leftovers();
            while (owed.size() != 0)
            begin
                void'(owed.pop_front());
                report_mismatch("verdict never delivered");
            end
        endtask
    endclass

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [SECTOR_W-1:0]  start_sector   = '0;
    logic [LEN_W-1:0]     length_sectors = '0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic                 skip;
    logic                 matched;
    logic                 cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_W-1:0]     cfg_data       = '0;

    flow_verdict_board board = new();

    // Set by the stimulus, consumed by the receiver process.
    bit hold_request = 0;
    int cycle_count  = 0;

    // Stream cursors used to build well-formed sequential traffic.
    logic [SECTOR_W-1:0] cur_next  [STREAM_COUNT];
    logic [SECTOR_W-1:0] cur_start [STREAM_COUNT];
    logic [LEN_W-1:0]    cur_len   [STREAM_COUNT];
    int                  burst_left = 0;

    sequential_io_stream_detector u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .start_sector   (start_sector),
        .length_sectors (length_sectors),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .skip           (skip),
        .matched        (matched),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Check every result beat against the oldest pending verdict.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(skip, matched);
    end

    // Receiver: stall density is redrawn at random among none, light, medium and heavy;
    // on request, hold off for a long stretch so the block backs up.
    initial
    begin
        int pct;
        int left;
        pct  = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 30;
                        2: pct = 60;
                        default: pct = 90;
                    endcase
                    left = 50;
                end
                left--;
                out_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    function automatic logic [SECTOR_W-1:0] rand_sector();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Offer one beat, hold it until the block takes it, then drop valid.
    task automatic send_beat(input logic [SECTOR_W-1:0] s, input logic [LEN_W-1:0] l);
        @(negedge clk);
        in_valid       <= 1'b1;
        start_sector   <= s;
        length_sectors <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(s, l);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Drop valid and wait until every verdict is in, then let the pipe settle.
    task automatic drain();
        idle_cycles(1);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] fgap,
                              input logic [CFG_W-1:0] bgap);
        write_reg(siosd_pkg::REG_SEQ_THRESHOLD, thr);
        write_reg(siosd_pkg::REG_FORWARD_GAP, fgap);
        write_reg(siosd_pkg::REG_BACKWARD_GAP, bgap);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] rand_len();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom);
        return LEN_W'($urandom_range(1, 256));
    endfunction

    // Random traffic: mostly sequential streams, with repeats, out-of-order
    // hits, noise and restarts mixed in. The sender works in bursts.
    task automatic random_requests(input int n);
        int                  idx;
        int                  roll;
        int                  back;
        req_kind_t           kind;
        logic [SECTOR_W-1:0] s;
        logic [LEN_W-1:0]    l;
        for (int i = 0; i < n; i++)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 60));
                burst_left = $urandom_range(1, 20);
            end
            burst_left--;
            idx  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, HOT_STREAMS - 1)
                                               : $urandom_range(0, STREAM_COUNT - 1);
            roll = $urandom_range(0, 99);
            if (roll < 55)      kind = KIND_FORWARD;
            else if (roll < 65) kind = KIND_REPEAT;
            else if (roll < 75) kind = KIND_BACKWARD;
            else if (roll < 90) kind = KIND_NOISE;
            else                kind = KIND_RESTART;
            case (kind)
                KIND_FORWARD:
                begin
                    s = cur_next[idx];
                    if ($urandom_range(0, 9) >= 6)
                        s = s + SECTOR_W'($urandom_range(1, 80));
                    l = rand_len();
                    cur_start[idx] = s;
                    cur_len[idx]   = l;
                    cur_next[idx]  = s + SECTOR_W'(l);
                end
                KIND_REPEAT:
                begin
                    s = cur_start[idx];
                    l = cur_len[idx];
                end
                KIND_BACKWARD:
                begin
                    back = $urandom_range(0, 40);
                    s    = cur_next[idx] - SECTOR_W'(back);
                    l    = LEN_W'($urandom_range(0, back));
                end
                KIND_NOISE:
                begin
                    s = rand_sector();
                    l = 16'($urandom);
                end
                default:
                begin
                    // restart the stream, sometimes right below the top of the sector space
                    s = ($urandom_range(0, 3) == 0)
                        ? SECTOR_W'(SECTOR_LIMIT) - SECTOR_W'($urandom_range(0, 4096))
                        : rand_sector();
                    l = rand_len();
                    cur_start[idx] = s;
                    cur_len[idx]   = l;
                    cur_next[idx]  = s + SECTOR_W'(l);
                end
            endcase
            send_beat(s, l);
        end
    endtask

    // Hand-picked requests at threshold 8, forward gap 32 and backward gap 16 sectors.
    task automatic directed_requests();
        send_beat('0, '0);                       // all-zero request repeats an empty slot
        send_beat('1, '1);                       // widest start and length, no flow fits
        send_beat('1, '1);                       // exact repeat
        send_beat(48'd1000, 16'd8);              // new flow
        send_beat(48'd1008, 16'd8);              // back-to-back continuation passes threshold
        send_beat(48'd1008, 16'd8);              // repeat: no skip
        send_beat(48'd1020, 16'd4);              // small hole inside the forward window
        send_beat(48'd1010, 16'd4);              // out-of-order hit inside the backward window
        send_beat(48'd1007, 16'd4);              // one sector below the backward window
        send_beat(48'd1044, 16'd2);              // forward hole exactly at the window edge
        send_beat(48'd1069, 16'd2);              // one sector past the window
        send_beat(48'd2000, 16'd0);              // zero-length request
        send_beat(48'd2000, 16'd0);
        send_beat(48'hFFFF_FFFF_FF00, 16'h00FF); // flow ending at the last sector
        send_beat(48'hFFFF_FFFF_FFFF, 16'd1);    // continuation runs past the sector space
        send_beat(48'h5555_5555_5555, 16'hAAAA);
        send_beat(48'h5555_5555_5555 + 48'hAAAA, 16'h5555);
        send_beat(48'hAAAA_AAAA_AAAA, 16'h8000);
    endtask

    initial
    begin
        for (int i = 0; i < STREAM_COUNT; i++)
        begin
            cur_start[i] = rand_sector();
            cur_len[i]   = rand_len();
            cur_next[i]  = cur_start[i] + SECTOR_W'(cur_len[i]);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Registers at reset: detection off, every verdict is zero.
        random_requests(40);
        drain();

        set_config(20'd4, 20'd16, 20'd8);
        directed_requests();
        random_requests(300);
        drain();

        // Widest settings.
        set_config('1, '1, '1);
        random_requests(250);
        drain();

        // Tightest settings: no hole allowed, backward hits off.
        set_config(20'd1, 20'd0, 20'd0);
        random_requests(250);
        drain();

        // Stray write to the unmapped index, then a long receiver hold-off
        // while the sender keeps offering beats.
        write_reg(REG_UNMAPPED, '1);
        set_config(20'd64, 20'd512, 20'd64);
        hold_request = 1;
        random_requests(300);
        drain();

        // Detection switched off mid-run, then back on.
        set_config(20'd0, 20'd100, 20'd100);
        random_requests(60);
        drain();
        set_config(20'd1, 20'd2, '1);
        random_requests(200);
        drain();

        board.flush_leftovers();
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/siosd_pkg.sv
src/siosd_ram.sv
src/siosd_match.sv
src/sequential_io_stream_detector.sv
src/siosd_checker.sv
tb/sv/sequential_io_stream_detector_test.sv
